// ----- hw/rtl/brj_pkg.sv -----
// ----------------------------------------------------------------------------
// brj_pkg
// Shared types, constants and the arctangent table for the bearing residual
// and Jacobian unit.
// ----------------------------------------------------------------------------
package brj_pkg;

	localparam int POS_WIDTH_DEF     = 32;
	localparam int ANGLE_WIDTH_DEF   = 16;
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int ATAN_LEN          = 24;

	// CORDIC datapath: vectors normalized to [2^40, 2^41), gain and fold headroom
	localparam int CORDIC_W = 45;
	localparam int ZW       = 32;

	// atan(2^-i) as 32-bit binary angle, 2^31 = pi
	localparam logic [ZW-1:0] ATAN_TAB [ATAN_LEN] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81
	};

	localparam logic [ZW-1:0] ANGLE_PI = 32'h8000_0000;

	typedef enum logic [1:0] {
		REG_MARKER_X      = 2'd0,
		REG_MARKER_Y      = 2'd1,
		REG_SENSOR_OFFSET = 2'd2
	} cfg_reg_t;

	// vector handed from one CORDIC cell to the next
	typedef struct packed {
		logic signed [CORDIC_W-1:0] x;
		logic signed [CORDIC_W-1:0] y;
		logic [ZW-1:0]              z;
		logic                       zero;
	} cvec_t;

endpackage

// ----- hw/rtl/bearing_residual_jacobian_unit.sv -----
// ----------------------------------------------------------------------------
// bearing_residual_jacobian_unit
// Pipeline: 42 register stages from the accepting edge to result valid,
// at any parameter value.
// Throughput: one item per cycle; the whole row of cells shares one advance
// enable, which drops only while the final result register is held.
// Most of the stages are the 33-cell restoring divider chain of the Jacobian path.
// Reset clears the valid chain and the configuration registers (all zero).
// ----------------------------------------------------------------------------
module bearing_residual_jacobian_unit #(
	parameter int POS_WIDTH     = brj_pkg::POS_WIDTH_DEF,
	parameter int ANGLE_WIDTH   = brj_pkg::ANGLE_WIDTH_DEF,
	parameter int CORDIC_STAGES = brj_pkg::CORDIC_STAGES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [((POS_WIDTH > ANGLE_WIDTH) ? POS_WIDTH : ANGLE_WIDTH)-1:0] cfg_data,
	// item channel
	input  logic                          item_valid,
	output logic                          item_ready,
	input  logic signed [POS_WIDTH-1:0]   pose_x,
	input  logic signed [POS_WIDTH-1:0]   pose_y,
	input  logic signed [15:0]            rot_r0c0,
	input  logic signed [15:0]            rot_r0c1,
	input  logic signed [15:0]            rot_r0c2,
	input  logic signed [15:0]            rot_r1c0,
	input  logic signed [15:0]            rot_r1c1,
	input  logic signed [15:0]            rot_r1c2,
	input  logic signed [ANGLE_WIDTH-1:0] measured_bearing,
	// result channel
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic signed [ANGLE_WIDTH-1:0] residual,
	output logic signed [31:0]            jac_tx,
	output logic signed [31:0]            jac_ty,
	output logic signed [31:0]            jac_tz,
	output logic                          degenerate
);
	import brj_pkg::*;

	localparam int AW   = ANGLE_WIDTH;
	localparam int DW   = POS_WIDTH + 1;                 // marker - pose
	localparam int NC   = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;
	// Jacobian scaling: shift brings max(|dx|,|dy|) below 2^23
	localparam int SMAX = (POS_WIDTH > 22) ? POS_WIDTH - 22 : 0;
	localparam int S_W  = (SMAX > 0) ? $clog2(SMAX + 1) : 1;
	localparam int NUM_W = 58;                           // |n| < 2^40, up to << 18
	localparam int DEN_W = 47 + ((SMAX > 18) ? SMAX - 18 : 0);
	localparam int Q_W   = 33;                           // quotient bits 32..0
	localparam int R_W   = ((NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W) + 1;
	// stage map
	localparam int L       = Q_W + 9;                    // final output register
	localparam int ANG_END = NC + 4;                     // residual formed here

	// ---------------------------------------------------------------- config
	logic signed [POS_WIDTH-1:0] marker_x_q, marker_y_q;
	logic [AW-1:0]               sensor_offset_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_x_q      <= '0;
			marker_y_q      <= '0;
			sensor_offset_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_MARKER_X:      marker_x_q      <= cfg_data[POS_WIDTH-1:0];
				REG_MARKER_Y:      marker_y_q      <= cfg_data[POS_WIDTH-1:0];
				REG_SENSOR_OFFSET: sensor_offset_q <= cfg_data[AW-1:0];
				default: ;  // unknown index, write dropped
			endcase
		end
	end

	// ---------------------------------------------------------- flow control
	// One enable moves every stage; valid bits ride along.
	logic       en;
	logic [L:1] vld_q;

	assign en           = !vld_q[L] || result_ready;
	assign item_ready   = en;
	assign result_valid = vld_q[L];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[L-1:1], item_valid};
		end
	end

	// --------------------------------------------------------------- stage 1
	logic signed [DW-1:0] dx_s1, dy_s1;
	logic signed [15:0]   rot_s1 [6];
	logic [AW-1:0]        meas_s [1:NC+3];

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1     <= DW'(marker_x_q) - DW'(pose_x);
			dy_s1     <= DW'(marker_y_q) - DW'(pose_y);
			rot_s1[0] <= rot_r0c0;
			rot_s1[1] <= rot_r0c1;
			rot_s1[2] <= rot_r0c2;
			rot_s1[3] <= rot_r1c0;
			rot_s1[4] <= rot_r1c1;
			rot_s1[5] <= rot_r1c2;
			meas_s[1] <= measured_bearing;
			for (int i = 2; i <= NC + 3; i++) begin
				meas_s[i] <= meas_s[i-1];
			end
		end
	end

	// ------------------------------------------------------------ angle path
	// Two atan2 chains: world bearing to the marker, and pose yaw.
	cvec_t bvec [NC+1];
	cvec_t yvec [NC+1];

	brj_cnorm #(.IN_W(DW)) u_bnorm (
		.clk(clk), .en(en), .x_i(dx_s1), .y_i(dy_s1), .vec_o(bvec[0])
	);

	brj_cnorm #(.IN_W(16)) u_ynorm (
		.clk(clk), .en(en), .x_i(rot_s1[0]), .y_i(rot_s1[3]), .vec_o(yvec[0])
	);

	for (genvar c = 0; c < NC; c++) begin : g_cordic
		brj_ccell #(.IDX(c)) u_bcell (
			.clk(clk), .en(en), .vec_i(bvec[c]), .vec_o(bvec[c+1])
		);
		brj_ccell #(.IDX(c)) u_ycell (
			.clk(clk), .en(en), .vec_i(yvec[c]), .vec_o(yvec[c+1])
		);
	end

	// round half up to AW bits; a zero vector gives angle zero
	logic [ZW-1:0] bz, yz;
	logic [AW-1:0] bw_ang, yaw_ang;
	logic [AW-1:0] res_s [ANG_END:L];

	always_comb begin
		bz      = (bvec[NC].zero ? '0 : bvec[NC].z) + (ZW'(1) << (31 - AW));
		yz      = (yvec[NC].zero ? '0 : yvec[NC].z) + (ZW'(1) << (31 - AW));
		bw_ang  = bz[ZW-1 -: AW];
		yaw_ang = yz[ZW-1 -: AW];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s[ANG_END] <= bw_ang - yaw_ang - sensor_offset_q - meas_s[NC+3];
			for (int i = ANG_END + 1; i <= L; i++) begin
				res_s[i] <= res_s[i-1];
			end
		end
	end

	// --------------------------------------------------------- Jacobian path
	logic [DW-1:0]       adx_s2, ady_s2, m_s2, adx_s3, ady_s3;
	logic                negx_s2, negy_s2, negx_s3, negy_s3;
	logic                degen_s [2:L];
	logic [S_W-1:0]      s_s3, s_s4, s_s5, s_s6;
	logic signed [15:0]  rot_s2 [6];
	logic signed [15:0]  rot_s3 [6];
	logic signed [15:0]  rot_s4 [6];
	logic [S_W-1:0]      sh;
	logic [63:0]         tx, ty;
	logic signed [23:0]  dxp_s4, dyp_s4;
	logic signed [47:0]  sqx_p, sqy_p;
	logic [45:0]         sqx_s5, sqy_s5;
	logic signed [39:0]  pa_s5 [3];
	logic signed [39:0]  pb_s5 [3];
	logic [46:0]         den0_s6;
	logic signed [40:0]  n_s6 [3];
	logic [39:0]         nmag [3];
	logic [NUM_W-1:0]    num_s7 [3];
	logic [DEN_W-1:0]    den_s7;
	logic                neg_s [7:L-1][3];
	logic                ovf_s [8:L-1][3];

	always_comb begin
		sh = '0;
		for (int i = 23; i < DW; i++) begin
			if (m_s2[i]) begin
				sh = S_W'(i - 22);
			end
		end
		tx    = 64'(adx_s3) >> s_s3;
		ty    = 64'(ady_s3) >> s_s3;
		sqx_p = dxp_s4 * dxp_s4;
		sqy_p = dyp_s4 * dyp_s4;
		for (int j = 0; j < 3; j++) begin
			nmag[j] = n_s6[j][40] ? 40'(-n_s6[j]) : 40'(n_s6[j]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// s2: magnitudes, pose-on-marker flag
			adx_s2     <= dx_s1[DW-1] ? DW'(-dx_s1) : DW'(dx_s1);
			ady_s2     <= dy_s1[DW-1] ? DW'(-dy_s1) : DW'(dy_s1);
			m_s2       <= ((dx_s1[DW-1] ? DW'(-dx_s1) : DW'(dx_s1)) >
			               (dy_s1[DW-1] ? DW'(-dy_s1) : DW'(dy_s1))) ?
			              (dx_s1[DW-1] ? DW'(-dx_s1) : DW'(dx_s1)) :
			              (dy_s1[DW-1] ? DW'(-dy_s1) : DW'(dy_s1));
			negx_s2    <= dx_s1[DW-1];
			negy_s2    <= dy_s1[DW-1];
			degen_s[2] <= (dx_s1 == '0) && (dy_s1 == '0);
			rot_s2     <= rot_s1;
			// s3: range shift
			s_s3    <= sh;
			adx_s3  <= adx_s2;
			ady_s3  <= ady_s2;
			negx_s3 <= negx_s2;
			negy_s3 <= negy_s2;
			rot_s3  <= rot_s2;
			// s4: scaled signed difference
			dxp_s4 <= negx_s3 ? -24'(tx[22:0]) : 24'(tx[22:0]);
			dyp_s4 <= negy_s3 ? -24'(ty[22:0]) : 24'(ty[22:0]);
			s_s4   <= s_s3;
			rot_s4 <= rot_s3;
			// s5: products
			sqx_s5 <= sqx_p[45:0];
			sqy_s5 <= sqy_p[45:0];
			for (int j = 0; j < 3; j++) begin
				pa_s5[j] <= dyp_s4 * rot_s4[j];
				pb_s5[j] <= dxp_s4 * rot_s4[j+3];
			end
			s_s5 <= s_s4;
			// s6: r2 and numerators
			den0_s6 <= 47'(sqx_s5) + 47'(sqy_s5);
			for (int j = 0; j < 3; j++) begin
				n_s6[j] <= 41'(pa_s5[j]) - 41'(pb_s5[j]);
			end
			s_s6 <= s_s5;
			// s7: align numerator and divisor for Q16.16 with the 2^s scale
			for (int j = 0; j < 3; j++) begin
				neg_s[7][j] <= n_s6[j][40];
				num_s7[j]   <= (int'(s_s6) <= 18) ?
				               (NUM_W'(nmag[j]) << (18 - int'(s_s6))) : NUM_W'(nmag[j]);
			end
			den_s7 <= (int'(s_s6) <= 18) ?
			          DEN_W'(den0_s6) : (DEN_W'(den0_s6) << (int'(s_s6) - 18));
			// side flags down the row
			for (int i = 3; i <= L; i++) begin
				degen_s[i] <= degen_s[i-1];
			end
			for (int i = 8; i <= L - 1; i++) begin
				neg_s[i] <= neg_s[i-1];
			end
		end
	end

	// s8: quotient of 2^33 or more saturates; otherwise 33 divider cells
	logic [R_W-1:0]   rem_s8 [3];
	logic [DEN_W-1:0] den_s8 [3];
	wire  [R_W-1:0]   rem_c [3][Q_W+1];
	wire  [Q_W-1:0]   q_c   [3][Q_W+1];
	wire  [DEN_W-1:0] den_c [3][Q_W+1];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				ovf_s[8][j] <= (R_W'(num_s7[j]) >= (R_W'(den_s7) << Q_W));
				rem_s8[j]   <= R_W'(num_s7[j]);
				den_s8[j]   <= den_s7;
			end
			for (int i = 9; i <= L - 1; i++) begin
				ovf_s[i] <= ovf_s[i-1];
			end
		end
	end

	for (genvar j = 0; j < 3; j++) begin : g_entry
		assign rem_c[j][0] = rem_s8[j];
		assign q_c[j][0]   = '0;
		assign den_c[j][0] = den_s8[j];
		for (genvar c = 1; c <= Q_W; c++) begin : g_div
			brj_dcell #(.R_W(R_W), .DEN_W(DEN_W), .Q_W(Q_W), .K(Q_W - c)) u_dcell (
				.clk(clk), .en(en),
				.rem_i(rem_c[j][c-1]), .q_i(q_c[j][c-1]), .den_i(den_c[j][c-1]),
				.rem_o(rem_c[j][c]),   .q_o(q_c[j][c]),   .den_o(den_c[j][c])
			);
		end
	end

	// final stage: saturate to Q16.16, zero on pose-on-marker
	logic [31:0] jac_w [3];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			if (degen_s[L-1]) begin
				jac_w[j] = '0;
			end else if (neg_s[L-1][j]) begin
				jac_w[j] = (ovf_s[L-1][j] || q_c[j][Q_W] > 33'h0_8000_0000) ?
				           32'h8000_0000 : -q_c[j][Q_W][31:0];
			end else begin
				jac_w[j] = (ovf_s[L-1][j] || q_c[j][Q_W] > 33'h0_7FFF_FFFF) ?
				           32'h7FFF_FFFF : q_c[j][Q_W][31:0];
			end
		end
	end

	logic signed [31:0] jac_s42 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				jac_s42[j] <= jac_w[j];
			end
		end
	end

	assign residual   = res_s[L];
	assign jac_tx     = jac_s42[0];
	assign jac_ty     = jac_s42[1];
	assign jac_tz     = jac_s42[2];
	assign degenerate = degen_s[L];

`ifndef SYNTHESIS
	// r2 is zero only when the pose sits on the marker
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[6] && !degen_s[6] |-> den0_s6 != '0)
		else $error("r2 zero on a non-degenerate item");

	// degenerate results carry zero Jacobians
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && degenerate |-> jac_tx == 0 && jac_ty == 0 && jac_tz == 0)
		else $error("nonzero Jacobian on degenerate result");
`endif

endmodule

// ----- hw/rtl/brj_cnorm.sv -----
// ----------------------------------------------------------------------------
// brj_cnorm
// Two-stage front end of an atan2 chain: magnitude scaling to [2^40, 2^41)
// and left half plane fold.
// ----------------------------------------------------------------------------
module brj_cnorm #(
	parameter int IN_W = 33
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic signed [IN_W-1:0] x_i,
	input  logic signed [IN_W-1:0] y_i,
	output brj_pkg::cvec_t         vec_o
);
	import brj_pkg::*;

	logic [IN_W-1:0] ax, ay, m;
	logic [6:0]      blen;

	logic [IN_W-1:0] ax_s1, ay_s1;
	logic            negx_s1, negy_s1, zero_s1;
	logic [6:0]      blen_s1;

	logic [63:0]          mx, my;
	logic                 fold;
	logic signed [CORDIC_W-1:0] xm, ym;

	always_comb begin
		ax = x_i[IN_W-1] ? IN_W'(-x_i) : IN_W'(x_i);
		ay = y_i[IN_W-1] ? IN_W'(-y_i) : IN_W'(y_i);
		m  = (ax > ay) ? ax : ay;
		blen = '0;
		for (int i = 0; i < IN_W; i++) begin
			if (m[i]) begin
				blen = 7'(i + 1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1   <= ax;
			ay_s1   <= ay;
			negx_s1 <= x_i[IN_W-1];
			negy_s1 <= y_i[IN_W-1];
			zero_s1 <= (m == '0);
			blen_s1 <= blen;
		end
	end

	// magnitude truncation toward zero, sign reapplied afterwards
	always_comb begin
		if (blen_s1 > 7'd41) begin
			mx = 64'(ax_s1) >> (blen_s1 - 7'd41);
			my = 64'(ay_s1) >> (blen_s1 - 7'd41);
		end else begin
			mx = 64'(ax_s1) << (7'd41 - blen_s1);
			my = 64'(ay_s1) << (7'd41 - blen_s1);
		end
		fold = negx_s1 && (mx[40:0] != '0);
		xm   = CORDIC_W'(mx[40:0]);
		ym   = CORDIC_W'(my[40:0]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vec_o.x    <= xm;
			vec_o.y    <= (negy_s1 ^ fold) ? -ym : ym;
			vec_o.z    <= fold ? ANGLE_PI : '0;
			vec_o.zero <= zero_s1;
		end
	end

endmodule

// ----- hw/rtl/brj_ccell.sv -----
// ----------------------------------------------------------------------------
// brj_ccell
// One vectoring CORDIC micro-rotation, registered.
// ----------------------------------------------------------------------------
module brj_ccell #(
	parameter int IDX = 0
) (
	input  logic           clk,
	input  logic           en,
	input  brj_pkg::cvec_t vec_i,
	output brj_pkg::cvec_t vec_o
);
	import brj_pkg::*;

	logic signed [CORDIC_W-1:0] xs, ys;
	logic                       pos;

	assign xs  = vec_i.x >>> IDX;
	assign ys  = vec_i.y >>> IDX;
	assign pos = (vec_i.y > 0);

	always_ff @(posedge clk) begin
		if (en) begin
			vec_o.x    <= pos ? vec_i.x + ys : vec_i.x - ys;
			vec_o.y    <= pos ? vec_i.y - xs : vec_i.y + xs;
			vec_o.z    <= pos ? vec_i.z + ATAN_TAB[IDX] : vec_i.z - ATAN_TAB[IDX];
			vec_o.zero <= vec_i.zero;
		end
	end

endmodule

// ----- hw/rtl/brj_dcell.sv -----
// ----------------------------------------------------------------------------
// brj_dcell
// One restoring division step: decides quotient bit K, registered.
// ----------------------------------------------------------------------------
module brj_dcell #(
	parameter int R_W   = 81,
	parameter int DEN_W = 47,
	parameter int Q_W   = 33,
	parameter int K     = 0
) (
	input  logic             clk,
	input  logic             en,
	input  logic [R_W-1:0]   rem_i,
	input  logic [Q_W-1:0]   q_i,
	input  logic [DEN_W-1:0] den_i,
	output logic [R_W-1:0]   rem_o,
	output logic [Q_W-1:0]   q_o,
	output logic [DEN_W-1:0] den_o
);

	logic [R_W-1:0] dsh;
	logic           ge;

	assign dsh = R_W'(den_i) << K;
	assign ge  = (rem_i >= dsh);

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o <= ge ? rem_i - dsh : rem_i;
			q_o   <= ge ? (q_i | (Q_W'(1) << K)) : q_i;
			den_o <= den_i;
		end
	end

endmodule
